// ----- rtl/core/cfd_pkg.sv -----
// cfd_pkg: shared types and constants of the byte-stuffing frame decoder
// used by cfd_front, cfd_queue, cfd_back and cobs_frame_decoder
package cfd_pkg;

  localparam logic [7:0] DELIM_RESET = 8'd10;
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QUEUE_AW = $clog2(QUEUE_DEPTH);
  localparam int unsigned QUEUE_CW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [15:0] COUNT_MAX = 16'hFFFF;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       frame_end;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  out_byte;
    logic        has_byte;
    logic        frame_done;
    logic        frame_error;
    logic [15:0] frame_length;
  } out_item_t;

  // classified command handed from front to back
  typedef struct packed {
    logic [7:0] data;
    logic       emit;
    logic       last;
    logic       err;
  } cmd_t;

endpackage

// ----- rtl/core/cobs_frame_decoder.sv -----
// cobs_frame_decoder: top level of the byte-stuffing frame decoder
// uses cfd_pkg, cfd_front, cfd_queue, cfd_back
//
// Usage:
//  - in_*: one encoded byte per transaction with a frame_end flag on the
//    last byte of a frame; valid/ready handshake.
//  - out_*: zero or one result per input byte: a decoded byte (has_byte)
//    and/or the closing result with frame_done, frame_error, frame_length.
//  - cfg_*: writes the delimiter byte (reset value newline); cfg_ready is
//    always high, write only while the decoder is idle.
//  - path: each result is written into the command queue and then into
//    the output register, from which out_valid and out_data are driven.
//  - throughput: one byte per cycle; the front takes a byte whenever the
//    four-entry command queue has room, so in_ready drops only after the
//    receiver has held out_ready low long enough to fill that queue.
//  - a receiver stall holds the result in the output register; bytes that
//    yield no result never use queue space.
//  - reset (synchronous, rst_n low) empties queue and output register,
//    restores the delimiter and starts awaiting a new frame.
module cobs_frame_decoder (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  cfd_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output cfd_pkg::out_item_t out_data,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [7:0]         cfg_data
);

  logic          [7:0] delim_r;
  logic                q_full;
  logic                q_push;
  cfd_pkg::cmd_t       q_push_data;
  logic                q_pop;
  logic                q_not_empty;
  cfd_pkg::cmd_t       q_head;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      delim_r <= cfd_pkg::DELIM_RESET;
    end else if (cfg_valid && cfg_ready) begin
      delim_r <= cfg_data;
    end
  end

  cfd_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .delim    (delim_r),
    .q_full   (q_full),
    .cmd_push (q_push),
    .cmd_data (q_push_data)
  );

  cfd_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_push_data),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .head      (q_head)
  );

  cfd_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (q_not_empty),
    .cmd_data  (q_head),
    .cmd_pop   (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// ----- rtl/core/cfd_front.sv -----
// cfd_front: accepts encoded bytes, tracks group codes and errors, and
// issues one command per byte that yields a result; uses cfd_pkg
module cfd_front (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  cfd_pkg::in_item_t in_data,
  input  logic [7:0]      delim,
  input  logic            q_full,
  output logic            cmd_push,
  output cfd_pkg::cmd_t   cmd_data
);

  logic       expect_r, expect_nxt;
  logic [7:0] left_r, left_nxt;
  logic       err_r, err_nxt;
  logic       is_delim;
  logic [7:0] unmapped;
  logic       emit;
  logic [7:0] emit_byte;
  logic       accept;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign is_delim = (in_data.in_byte == delim);
  assign unmapped = (in_data.in_byte > delim) ? in_data.in_byte - 8'd1 : in_data.in_byte;

  always_comb begin
    expect_nxt = expect_r;
    left_nxt   = left_r;
    err_nxt    = err_r;
    emit       = 1'b0;
    emit_byte  = 8'd0;
    priority if (is_delim) begin
      err_nxt    = 1'b1;
      expect_nxt = 1'b0;
    end else if (err_r) begin
      // bytes after an error are dropped
      err_nxt = 1'b1;
    end else begin
      priority if (expect_r) begin
        left_nxt   = unmapped;
        expect_nxt = 1'b0;
      end else if (left_r == 8'd0) begin
        // code byte inside the frame stands for one delimiter
        left_nxt  = unmapped;
        emit      = 1'b1;
        emit_byte = delim;
      end else begin
        left_nxt  = left_r - 8'd1;
        emit      = 1'b1;
        emit_byte = in_data.in_byte;
      end
    end
  end

  assign cmd_push      = accept && (emit || in_data.frame_end);
  assign cmd_data.data = emit_byte;
  assign cmd_data.emit = emit;
  assign cmd_data.last = in_data.frame_end;
  assign cmd_data.err  = err_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      expect_r <= 1'b1;
      left_r   <= 8'd0;
      err_r    <= 1'b0;
    end else if (accept) begin
      if (in_data.frame_end) begin
        expect_r <= 1'b1;
        left_r   <= 8'd0;
        err_r    <= 1'b0;
      end else begin
        expect_r <= expect_nxt;
        left_r   <= left_nxt;
        err_r    <= err_nxt;
      end
    end
  end

  // once an error is flagged nothing more is emitted in that frame
  a_no_emit_after_err: assert property (@(posedge clk) disable iff (!rst_n)
    err_r |-> !cmd_data.emit)
    else $error("front emitted a byte after a frame error");

endmodule

// ----- rtl/core/cfd_queue.sv -----
// cfd_queue: small flip-flop fifo of commands between front and back
// uses cfd_pkg
module cfd_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  cfd_pkg::cmd_t push_data,
  output logic          full,
  input  logic          pop,
  output logic          not_empty,
  output cfd_pkg::cmd_t head
);

  cfd_pkg::cmd_t                     mem_r [cfd_pkg::QUEUE_DEPTH];
  logic [cfd_pkg::QUEUE_AW-1:0]      wr_ptr_r, rd_ptr_r;
  logic [cfd_pkg::QUEUE_CW-1:0]      count_r, count_nxt;
  logic                              do_push, do_pop;

  assign full      = (count_r == cfd_pkg::QUEUE_CW'(cfd_pkg::QUEUE_DEPTH));
  assign not_empty = (count_r != '0);
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;
  assign head      = mem_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    unique case ({do_push, do_pop})
      2'b10:   count_nxt = count_r + 1'b1;
      2'b01:   count_nxt = count_r - 1'b1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (do_pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      count_r <= count_nxt;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= cfd_pkg::QUEUE_CW'(cfd_pkg::QUEUE_DEPTH))
    else $error("queue count beyond depth");

  a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (wr_ptr_r - rd_ptr_r) == count_r[cfd_pkg::QUEUE_AW-1:0])
    else $error("queue pointers disagree with count");

endmodule

// ----- rtl/core/cfd_back.sv -----
// cfd_back: counts decoded bytes per frame and builds results into the
// output register; uses cfd_pkg
module cfd_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cmd_valid,
  input  cfd_pkg::cmd_t     cmd_data,
  output logic              cmd_pop,
  output logic              out_valid,
  input  logic              out_ready,
  output cfd_pkg::out_item_t out_data
);

  logic [15:0]        count_r, count_nxt;
  logic               out_valid_r;
  cfd_pkg::out_item_t out_r, out_nxt;

  assign cmd_pop = cmd_valid && (!out_valid_r || out_ready);

  always_comb begin
    count_nxt = count_r;
    if (cmd_data.emit && count_r != cfd_pkg::COUNT_MAX) begin
      count_nxt = count_r + 16'd1;
    end
    out_nxt.out_byte     = cmd_data.emit ? cmd_data.data : 8'd0;
    out_nxt.has_byte     = cmd_data.emit;
    out_nxt.frame_done   = cmd_data.last;
    out_nxt.frame_error  = cmd_data.last && cmd_data.err;
    out_nxt.frame_length = (cmd_data.last && !cmd_data.err) ? count_nxt : 16'd0;
  end

  always_ff @(posedge clk) begin
    if (cmd_pop) begin
      out_r <= out_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= 16'd0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd_pop) begin
        count_r     <= cmd_data.last ? 16'd0 : count_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  a_len_only_done: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_r.frame_done) |-> (out_r.frame_length == 16'd0 && !out_r.frame_error))
    else $error("length or error outside a closing result");

  a_err_zero_len: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.frame_error) |-> (out_r.frame_length == 16'd0 && !out_r.has_byte))
    else $error("errored frame carries a length or byte");

  a_count_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd_pop && cmd_data.last) |=> (count_r == 16'd0))
    else $error("byte count not cleared after frame close");

endmodule

// ----- dv/cobs_frame_decoder_checker.sv -----
`timescale 1ns / 1ps
// cobs_frame_decoder_checker: watches the decoder's input, result and config
// channels, predicts each result and compares it field by field; uses cfd_pkg
module cobs_frame_decoder_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_ready,
  input  cfd_pkg::in_item_t  in_data,
  input  logic               out_valid,
  input  logic               out_ready,
  input  cfd_pkg::out_item_t out_data,
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  logic [7:0]         cfg_data,
  output int                 results_owed,
  output int                 fail_count
);

  logic [7:0] delim;
  logic       awaiting_code;
  logic [7:0] group_left;
  logic       frame_bad;
  logic [15:0] byte_count;

  cfd_pkg::out_item_t expected_results[$];

  function automatic logic [7:0] unstuff_code(input logic [7:0] code);
    return (code > delim) ? code - 8'd1 : code;
  endfunction

  function automatic void start_frame();
    awaiting_code = 1'b1;
    group_left = '0;
    frame_bad = 1'b0;
    byte_count = '0;
  endfunction

  // advances the decoder state by one byte, returns 1 when a result follows
  function automatic bit decode_byte(input cfd_pkg::in_item_t item,
                                     output cfd_pkg::out_item_t res);
    logic       emit;
    logic [7:0] value;
    emit = 1'b0;
    value = '0;
    if (item.in_byte == delim) begin
      frame_bad = 1'b1;
      awaiting_code = 1'b0;
    end else if (!frame_bad) begin
      if (awaiting_code) begin
        group_left = unstuff_code(item.in_byte);
        awaiting_code = 1'b0;
      end else if (group_left == 0) begin
        // a later code byte stands for one delimiter in the decoded data
        group_left = unstuff_code(item.in_byte);
        value = delim;
        emit = 1'b1;
      end else begin
        value = item.in_byte;
        emit = 1'b1;
        group_left = group_left - 8'd1;
      end
    end
    if (emit && byte_count != cfd_pkg::COUNT_MAX)
      byte_count = byte_count + 16'd1;
    res.out_byte = emit ? value : 8'd0;
    res.has_byte = emit;
    res.frame_done = item.frame_end;
    res.frame_error = item.frame_end && frame_bad;
    res.frame_length = (item.frame_end && !frame_bad) ? byte_count : 16'd0;
    if (item.frame_end)
      start_frame();
    return emit || item.frame_end;
  endfunction

  always @(posedge clk) begin
    cfd_pkg::out_item_t want;
    cfd_pkg::out_item_t pred;
    if (!rst_n) begin
      delim = cfd_pkg::DELIM_RESET;
      start_frame();
      expected_results.delete();
    end else begin
      if (cfg_valid && cfg_ready)
        delim = cfg_data;
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("unexpected result transaction: byte=%h has=%b done=%b err=%b len=%0d",
                     out_data.out_byte, out_data.has_byte, out_data.frame_done,
                     out_data.frame_error, out_data.frame_length);
        end else begin
          want = expected_results.pop_front();
          if (out_data.out_byte !== want.out_byte || out_data.has_byte !== want.has_byte ||
              out_data.frame_done !== want.frame_done ||
              out_data.frame_error !== want.frame_error ||
              out_data.frame_length !== want.frame_length) begin
            fail_count++;
            if (fail_count <= 10)
              $display("mismatch: expected byte=%h has=%b done=%b err=%b len=%0d,",
                       want.out_byte, want.has_byte, want.frame_done, want.frame_error,
                       want.frame_length,
                       " got byte=%h has=%b done=%b err=%b len=%0d",
                       out_data.out_byte, out_data.has_byte, out_data.frame_done,
                       out_data.frame_error, out_data.frame_length);
          end
        end
      end
      if (in_valid && in_ready) begin
        if (decode_byte(in_data, pred))
          expected_results.push_back(pred);
      end
    end
    results_owed <= expected_results.size();
  end

endmodule

// ----- dv/cobs_frame_decoder_tb.sv -----
`timescale 1ns / 1ps
// cobs_frame_decoder_tb: drives encoded frames and delimiter writes into the
// decoder and gives the verdict; uses cfd_pkg and cobs_frame_decoder_checker
module cobs_frame_decoder_tb;

  localparam int CYCLE_LIMIT = 600000;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  cfd_pkg::in_item_t  in_data = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  cfd_pkg::out_item_t out_data;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [7:0]         cfg_data = '0;

  int results_owed;
  int fail_count;
  int cycle_count = 0;
  int idle_pct = 0;
  int stall_pct = 0;
  logic hold_active = 1'b0;
  int bytes_sent = 0;
  logic [7:0] cur_delim = cfd_pkg::DELIM_RESET;
  logic [7:0] frame_bytes[$];

  cobs_frame_decoder dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  cobs_frame_decoder_checker chk (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .results_owed(results_owed), .fail_count(fail_count)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL cobs_frame_decoder");
      $finish;
    end
  end

  // receiver: random stalls, or a long hold-off while hold_active is set
  always @(posedge clk) begin
    if (hold_active)
      out_ready <= 1'b0;
    else
      out_ready <= ($urandom_range(99) >= stall_pct);
  end

  task automatic send_byte(input logic [7:0] b, input logic last);
    cfd_pkg::in_item_t item;
    item.in_byte = b;
    item.frame_end = last;
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= item;
    do @(posedge clk); while (!in_ready);
    bytes_sent++;
  endtask

  task automatic send_bytes(input logic close);
    for (int i = 0; i < frame_bytes.size(); i++)
      send_byte(frame_bytes[i], close && (i == frame_bytes.size() - 1));
  endtask

  // one code byte and n literals that avoid the current delimiter
  task automatic add_group(input int n);
    logic [7:0] b;
    frame_bytes.push_back(8'((n >= cur_delim) ? n + 1 : n));
    repeat (n) begin
      b = 8'($urandom_range(255));
      if (b == cur_delim)
        b = b + 8'd1;
      frame_bytes.push_back(b);
    end
  endtask

  task automatic send_random_frame();
    int kind;
    int cut;
    frame_bytes.delete();
    kind = $urandom_range(99);
    if (kind < 12) begin
      // noise: any byte values, delimiter included
      repeat ($urandom_range(1, 8))
        frame_bytes.push_back(8'($urandom_range(255)));
    end else begin
      repeat ($urandom_range(1, 3))
        add_group(($urandom_range(39) == 0) ? $urandom_range(254) : $urandom_range(5));
      if (kind < 20) begin
        cut = $urandom_range(frame_bytes.size() - 1);
        repeat (cut) void'(frame_bytes.pop_back());
      end else if (kind < 28) begin
        frame_bytes[$urandom_range(frame_bytes.size() - 1)] = cur_delim;
      end
    end
    send_bytes(1'b1);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (results_owed != 0);
    // the front holds no bytes, only its group and error state
    repeat (4) @(posedge clk);
  endtask

  task automatic write_delim(input logic [7:0] v);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    cur_delim = v;
  endtask

  task automatic run_phase(input logic [7:0] d, input int idle, input int stall,
                           input int count);
    int target;
    write_delim(d);
    idle_pct = idle;
    stall_pct <= stall;
    target = bytes_sent + count;
    while (bytes_sent < target)
      send_random_frame();
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed frames, newline delimiter
    frame_bytes = '{8'h01};
    send_bytes(1'b1);
    frame_bytes = '{8'h03, 8'h00, 8'hFF, 8'h7F, 8'h02, 8'h55, 8'hAA};
    send_bytes(1'b1);
    frame_bytes = '{8'h00, 8'h0B};
    send_bytes(1'b1);
    frame_bytes = '{8'h0A, 8'h05, 8'h06};
    send_bytes(1'b1);
    frame_bytes = '{8'h02, 8'h41, 8'h0A, 8'h42, 8'h43};
    send_bytes(1'b1);
    frame_bytes = '{8'hFF, 8'h11, 8'h22};
    send_bytes(1'b1);
    // delimiter changed while a frame is open
    frame_bytes = '{8'h02, 8'h61};
    send_bytes(1'b0);
    write_delim(8'h00);
    frame_bytes = '{8'h62, 8'h63};
    send_bytes(1'b1);

    run_phase(8'hFF, 0, 0, 200);
    run_phase(cfd_pkg::DELIM_RESET, 81, 0, 200);
    run_phase(8'h00, 0, 81, 200);
    run_phase(8'($urandom_range(255)), 24, 24, 250);

    // receiver holds off while the sender keeps offering transactions
    write_delim(cfd_pkg::DELIM_RESET);
    idle_pct = 0;
    stall_pct <= 0;
    fork
      begin
        hold_active <= 1'b1;
        repeat (300) @(posedge clk);
        hold_active <= 1'b0;
      end
      repeat (20) send_random_frame();
    join

    in_valid <= 1'b0;
    do @(posedge clk); while (results_owed != 0);
    repeat (10) @(posedge clk);
    if (fail_count == 0)
      $display("PASS cobs_frame_decoder");
    else
      $display("FAIL cobs_frame_decoder");
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/core/cfd_pkg.sv
rtl/core/cfd_front.sv
rtl/core/cfd_queue.sv
rtl/core/cfd_back.sv
rtl/core/cobs_frame_decoder.sv
dv/cobs_frame_decoder_checker.sv
dv/cobs_frame_decoder_tb.sv
